[sv/ocx_pkg.sv]
// ----------------------------------------------------------------------------
// ocx_pkg
// shared types and constants of the eight-opcode word machine executor
// ----------------------------------------------------------------------------
`default_nettype none

package ocx_pkg;

  // word memory depth default and register file size
  localparam int MemWordsDef = 65536;
  localparam int RegCount    = 8;

  localparam int WordW = 32;
  localparam int AddrW = 16;
  localparam int RegW  = 3;

  // item commands
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_EXEC    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  // instruction opcodes, bits 24..22
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } op_e;

  // instruction field positions
  localparam int OpLsb  = 22;
  localparam int RaLsb  = 19;
  localparam int RbLsb  = 16;

  // outcome of one executed instruction
  typedef struct packed {
    logic              reg_we;
    logic [RegW-1:0]   reg_idx;
    logic [WordW-1:0]  reg_val;
    logic              mem_we;
    logic              is_load;
    logic [AddrW-1:0]  mem_addr;
    logic [WordW-1:0]  mem_val;
    logic [AddrW-1:0]  next_pc;
    logic              halt;
  } exec_res_t;

endpackage

`default_nettype wire

[sv/ocx_ram.sv]
// ----------------------------------------------------------------------------
// ocx_ram
// generic single-port ram, one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ocx_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/ocx_alu.sv]
// ----------------------------------------------------------------------------
// ocx_alu
// decode and execute of one instruction word from its register operands
// ----------------------------------------------------------------------------
`default_nettype none

module ocx_alu
  import ocx_pkg::*;
(
  input  logic [WordW-1:0] inst_i,
  input  logic [WordW-1:0] a_i,
  input  logic [WordW-1:0] b_i,
  input  logic [AddrW-1:0] pc_i,
  output exec_res_t        res_o
);

  op_e              op;
  logic [RegW-1:0]  rb;
  logic [RegW-1:0]  rd;
  logic [AddrW-1:0] off;
  logic [AddrW-1:0] pc_inc;
  logic [AddrW-1:0] ea;

  assign op     = op_e'(inst_i[OpLsb +: 3]);
  assign rb     = inst_i[RbLsb +: RegW];
  assign rd     = inst_i[RegW-1:0];
  assign off    = inst_i[AddrW-1:0];
  assign pc_inc = AddrW'(pc_i + AddrW'(1));
  // only the low 16 bits of the sign-extended sum survive the wrap
  assign ea     = AddrW'(a_i[AddrW-1:0] + off);

  always_comb begin
    res_o          = '0;
    res_o.next_pc  = pc_inc;
    res_o.mem_addr = ea;
    case (op)
      OP_ADD: begin
        res_o.reg_we  = 1'b1;
        res_o.reg_idx = rd;
        res_o.reg_val = WordW'(a_i + b_i);
      end
      OP_NOR: begin
        res_o.reg_we  = 1'b1;
        res_o.reg_idx = rd;
        res_o.reg_val = ~(a_i | b_i);
      end
      OP_LW: begin
        res_o.is_load = 1'b1;
        res_o.reg_idx = rb;
      end
      OP_SW: begin
        res_o.mem_we  = 1'b1;
        res_o.mem_val = b_i;
      end
      OP_BEQ: begin
        if (a_i == b_i) begin
          res_o.next_pc = AddrW'(pc_inc + off);
        end
      end
      OP_JALR: begin
        res_o.reg_we  = 1'b1;
        res_o.reg_idx = rb;
        res_o.reg_val = WordW'(pc_inc);
        // link is written first, so a shared register jumps to pc + 1
        if (inst_i[RaLsb +: RegW] == rb) begin
          res_o.next_pc = pc_inc;
        end else begin
          res_o.next_pc = a_i[AddrW-1:0];
        end
      end
      OP_HALT: begin
        res_o.halt = 1'b1;
      end
      default: begin
      end
    endcase
    if (!res_o.mem_we) begin
      res_o.mem_addr = res_o.is_load ? ea : '0;
    end
  end

endmodule

`default_nettype wire

[sv/eight_opcode_cpu_executor_top.sv]
// ----------------------------------------------------------------------------
// eight_opcode_cpu_executor_top
// eight-opcode 32-bit word machine: load, execute-one-step and restart commands
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// command   in         start & !busy          command_i, address_i, data_i
// result    out        done_o (one cycle)     program_counter_o, halted_o,
//                                             reg_written_o, reg_index_o,
//                                             reg_value_o, mem_written_o,
//                                             mem_address_o, mem_value_o
//
// load, restart, unused code and execute while halted: result shown in the next cycle
// execute: fetch, register read and execute steps; lw adds a data read step, as the
//   single port of the word memory serves fetch and data access in turn
// busy is low again in the cycle the result is shown, so a new transaction
//   may start in that cycle; the receiver cannot stall the result
// reset clears pc, halt flag and register valid bits; word memory is not
//   cleared and holds anything until a word is written there
// ----------------------------------------------------------------------------
`default_nettype none

module eight_opcode_cpu_executor_top
  import ocx_pkg::*;
#(
  parameter int MEM_WORDS = MemWordsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              command_i,
  input  logic [AddrW-1:0]        address_i,
  input  logic signed [WordW-1:0] data_i,
  output logic                    done_o,
  output logic [AddrW-1:0]        program_counter_o,
  output logic                    halted_o,
  output logic                    reg_written_o,
  output logic [RegW-1:0]         reg_index_o,
  output logic signed [WordW-1:0] reg_value_o,
  output logic                    mem_written_o,
  output logic [AddrW-1:0]        mem_address_o,
  output logic signed [WordW-1:0] mem_value_o
);

  localparam int IdxW = $clog2(MEM_WORDS);
  // ceiling reciprocal, exact quotient for every 16-bit address when MEM_WORDS exceeds 128
  localparam logic [24:0] Recip =
    25'(((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));

  // address modulo memory depth, multiplications by constants only
  function automatic logic [IdxW-1:0] mem_idx(input logic [AddrW-1:0] a);
    logic [40:0] prod;
    logic [8:0]  quo;
    logic [16:0] rem;
    prod = 41'(a) * 41'(Recip);
    quo  = prod[40:32];
    rem  = 17'(a) - 17'(17'(quo) * 17'(MEM_WORDS));
    return rem[IdxW-1:0];
  endfunction

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e                state_q, state_d;
  logic [AddrW-1:0]      pc_q, pc_d;
  logic                  halt_q, halt_d;
  logic [RegCount-1:0]   rf_valid_q, rf_valid_d;
  logic [WordW-1:0]      inst_q, inst_d;
  logic                  done_q, done_d;
  logic [AddrW-1:0]      out_pc_q, out_pc_d;
  logic                  out_halt_q, out_halt_d;
  logic                  out_rw_q, out_rw_d;
  logic [RegW-1:0]       out_ridx_q, out_ridx_d;
  logic [WordW-1:0]      out_rval_q, out_rval_d;
  logic                  out_mw_q, out_mw_d;
  logic [AddrW-1:0]      out_maddr_q, out_maddr_d;
  logic [WordW-1:0]      out_mval_q, out_mval_d;

  // word memory port
  logic                  mem_we;
  logic [IdxW-1:0]       mem_addr;
  logic [WordW-1:0]      mem_wdata;
  logic [WordW-1:0]      mem_rdata;

  // register file, two copies for the two operand reads
  logic                  rf_we;
  logic [RegW-1:0]       rf_waddr;
  logic [WordW-1:0]      rf_wdata;
  logic [RegW-1:0]       rfa_addr;
  logic [RegW-1:0]       rfb_addr;
  logic [WordW-1:0]      rfa_rdata;
  logic [WordW-1:0]      rfb_rdata;

  logic [WordW-1:0]      op_a;
  logic [WordW-1:0]      op_b;
  logic [RegW-1:0]       inst_ra;
  logic [RegW-1:0]       inst_rb;
  exec_res_t             ex;

  assign busy = (state_q != S_IDLE);

  ocx_ram #(
    .Width (WordW),
    .Depth (MEM_WORDS)
  ) u_word_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  ocx_ram #(
    .Width (WordW),
    .Depth (RegCount)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .addr_i  (rfa_addr),
    .wdata_i (rf_wdata),
    .rdata_o (rfa_rdata)
  );

  ocx_ram #(
    .Width (WordW),
    .Depth (RegCount)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .addr_i  (rfb_addr),
    .wdata_i (rf_wdata),
    .rdata_o (rfb_rdata)
  );

  // registers not written since reset or restart read as zero
  assign inst_ra = inst_q[RaLsb +: RegW];
  assign inst_rb = inst_q[RbLsb +: RegW];
  assign op_a = rf_valid_q[inst_ra] ? rfa_rdata : '0;
  assign op_b = rf_valid_q[inst_rb] ? rfb_rdata : '0;

  ocx_alu u_alu (
    .inst_i (inst_q),
    .a_i    (op_a),
    .b_i    (op_b),
    .pc_i   (pc_q),
    .res_o  (ex)
  );

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    halt_d      = halt_q;
    rf_valid_d  = rf_valid_q;
    inst_d      = inst_q;
    done_d      = 1'b0;
    out_pc_d    = out_pc_q;
    out_halt_d  = out_halt_q;
    out_rw_d    = out_rw_q;
    out_ridx_d  = out_ridx_q;
    out_rval_d  = out_rval_q;
    out_mw_d    = out_mw_q;
    out_maddr_d = out_maddr_q;
    out_mval_d  = out_mval_q;

    mem_we      = 1'b0;
    mem_addr    = mem_idx(pc_q);
    mem_wdata   = WordW'(data_i);
    rf_we       = 1'b0;
    rf_waddr    = ex.reg_idx;
    rf_wdata    = ex.reg_val;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          // default result: current state, nothing written
          done_d      = 1'b1;
          out_pc_d    = pc_q;
          out_halt_d  = halt_q;
          out_rw_d    = 1'b0;
          out_ridx_d  = '0;
          out_rval_d  = '0;
          out_mw_d    = 1'b0;
          out_maddr_d = '0;
          out_mval_d  = '0;
          case (command_i)
            CMD_LOAD: begin
              mem_we   = 1'b1;
              mem_addr = mem_idx(address_i);
            end
            CMD_RESTART: begin
              pc_d       = '0;
              halt_d     = 1'b0;
              rf_valid_d = '0;
              out_pc_d   = '0;
              out_halt_d = 1'b0;
            end
            CMD_EXEC: begin
              if (!halt_q) begin
                // fetch at pc; result comes later
                done_d  = 1'b0;
                state_d = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        // instruction word arrives, operand reads issued from it
        inst_d  = mem_rdata;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        pc_d   = ex.next_pc;
        halt_d = halt_q | ex.halt;
        if (ex.is_load) begin
          mem_addr = mem_idx(ex.mem_addr);
          state_d  = S_LOAD;
        end else begin
          mem_we    = ex.mem_we;
          mem_addr  = mem_idx(ex.mem_addr);
          mem_wdata = ex.mem_val;
          rf_we     = ex.reg_we;
          if (ex.reg_we) begin
            rf_valid_d[ex.reg_idx] = 1'b1;
          end
          done_d      = 1'b1;
          out_pc_d    = ex.next_pc;
          out_halt_d  = halt_q | ex.halt;
          out_rw_d    = ex.reg_we;
          out_ridx_d  = ex.reg_idx;
          out_rval_d  = ex.reg_val;
          out_mw_d    = ex.mem_we;
          out_maddr_d = ex.mem_addr;
          out_mval_d  = ex.mem_val;
          state_d     = S_IDLE;
        end
      end
      S_LOAD: begin
        // loaded word goes to regB
        rf_we               = 1'b1;
        rf_waddr            = inst_rb;
        rf_wdata            = mem_rdata;
        rf_valid_d[inst_rb] = 1'b1;
        done_d              = 1'b1;
        out_pc_d            = pc_q;
        out_halt_d          = halt_q;
        out_rw_d            = 1'b1;
        out_ridx_d          = inst_rb;
        out_rval_d          = mem_rdata;
        out_mw_d            = 1'b0;
        out_maddr_d         = '0;
        out_mval_d          = '0;
        state_d             = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // operand reads go out while the instruction word is at the memory output
  always_comb begin
    if (state_q == S_FETCH) begin
      rfa_addr = mem_rdata[RaLsb +: RegW];
      rfb_addr = mem_rdata[RbLsb +: RegW];
    end else begin
      rfa_addr = rf_waddr;
      rfb_addr = rf_waddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      rf_valid_q  <= '0;
      inst_q      <= '0;
      done_q      <= 1'b0;
      out_pc_q    <= '0;
      out_halt_q  <= 1'b0;
      out_rw_q    <= 1'b0;
      out_ridx_q  <= '0;
      out_rval_q  <= '0;
      out_mw_q    <= 1'b0;
      out_maddr_q <= '0;
      out_mval_q  <= '0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      halt_q      <= halt_d;
      rf_valid_q  <= rf_valid_d;
      inst_q      <= inst_d;
      done_q      <= done_d;
      out_pc_q    <= out_pc_d;
      out_halt_q  <= out_halt_d;
      out_rw_q    <= out_rw_d;
      out_ridx_q  <= out_ridx_d;
      out_rval_q  <= out_rval_d;
      out_mw_q    <= out_mw_d;
      out_maddr_q <= out_maddr_d;
      out_mval_q  <= out_mval_d;
    end
  end

  assign done_o            = done_q;
  assign program_counter_o = out_pc_q;
  assign halted_o          = out_halt_q;
  assign reg_written_o     = out_rw_q;
  assign reg_index_o       = out_ridx_q;
  assign reg_value_o       = signed'(out_rval_q);
  assign mem_written_o     = out_mw_q;
  assign mem_address_o     = out_maddr_q;
  assign mem_value_o       = signed'(out_mval_q);

endmodule

`default_nettype wire

[sv/ocx_checker.sv]
// ----------------------------------------------------------------------------
// ocx_checker
// port-level checks of the executor, attached to the top level by bind
// ----------------------------------------------------------------------------
`default_nettype none

module ocx_checker
  import ocx_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    done_o,
  input  logic                    reg_written_o,
  input  logic [RegW-1:0]         reg_index_o,
  input  logic signed [WordW-1:0] reg_value_o,
  input  logic                    mem_written_o
);

  // a result is shown only once the block is free again
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // an accepted transaction either keeps the block busy or answers at once
  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither busy nor answered");

  // the block leaves busy only by giving a result
  a_busy_ends_in_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (busy || done_o))
    else $error("busy ended without a result");

  // one step writes at most one of a register and memory, never both
  a_one_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(reg_written_o && mem_written_o))
    else $error("register and memory written by one step");

  // fields of an unwritten register report zero
  a_reg_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !reg_written_o) |-> (reg_index_o == '0 && reg_value_o == '0))
    else $error("register fields set without a register write");

endmodule

bind eight_opcode_cpu_executor_top ocx_checker u_ocx_checker (.*);

`default_nettype wire
